// ===== hw/rtl/nmlv_pkg.sv =====
// shared types, constants and sequencer states for the label vote core
package nmlv_pkg;

	localparam int NUM_LABELS  = 256;
	localparam int COUNT_WIDTH = 8;
	localparam int LABEL_W     = 8;
	localparam int IDX_W       = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;

	typedef logic [LABEL_W-1:0]     label_t;
	typedef logic [IDX_W-1:0]       idx_t;
	typedef logic [COUNT_WIDTH-1:0] count_t;

	localparam count_t COUNT_TOP          = {COUNT_WIDTH{1'b1}};
	localparam idx_t   UNCLASSIFIED_LABEL = IDX_W'(1);
	localparam idx_t   LAST_IDX           = IDX_W'(NUM_LABELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_VOTE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// sequencer to histogram store
	typedef struct packed {
		idx_t   rd_addr;
		logic   wr_en;
		idx_t   wr_addr;
		count_t wr_data;
		logic   clear;
	} hist_req_t;

endpackage

// ===== hw/rtl/nmlv_ram.sv =====
// generic single write port ram with registered read
module nmlv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== hw/rtl/nmlv_hist.sv =====
// label histogram: count ram plus per-bin valid bits that clear all bins together
module nmlv_hist (
	input  logic               clk,
	input  logic               arst_n,
	input  nmlv_pkg::hist_req_t req,
	output nmlv_pkg::count_t   count
);
	import nmlv_pkg::*;

	logic [NUM_LABELS-1:0] valid_q;
	logic                  vld_s1;
	count_t                rd_data;

	nmlv_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_LABELS)
	) u_ram (
		.clk    (clk),
		.wr_en  (req.wr_en),
		.wr_addr(req.wr_addr),
		.wr_data(req.wr_data),
		.rd_addr(req.rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= valid_q[req.rd_addr];
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
		end
	end

	// a bin never written since the last clear reads as zero
	assign count = vld_s1 ? rd_data : '0;

endmodule

// ===== hw/rtl/nmlv_seq.sv =====
// sequencer with the shared increment and compare unit
module nmlv_seq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  nmlv_pkg::label_t    neighbor_label,
	input  logic                last_neighbor,
	input  logic                no_neighbors,
	input  nmlv_pkg::label_t    replaced_label,
	output nmlv_pkg::hist_req_t req,
	input  nmlv_pkg::count_t    count,
	output logic                result_valid,
	output nmlv_pkg::label_t    voted_label,
	output logic                keep_label
);
	import nmlv_pkg::*;

	state_t state_q, state_d;

	idx_t   lbl_q;
	logic   in_tbl_q;
	logic   last_q;
	logic   keep_q;
	idx_t   cnt_q;
	idx_t   tag_s1;
	logic   tag_vld_s1;
	idx_t   best_q;
	count_t best_cnt_q;

	logic   accept;
	logic   in_tbl;
	logic   excluded;
	count_t cand;
	logic   better;

	assign accept = start && (state_q == ST_IDLE);
	assign in_tbl = 32'(neighbor_label) < NUM_LABELS;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = no_neighbors ? ST_EMIT : ST_VOTE;
				end
			end
			ST_VOTE:  state_d = last_q ? ST_SCAN : ST_IDLE;
			ST_SCAN: begin
				if (cnt_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs and histogram requests
	always_comb begin
		req.rd_addr  = cnt_q;
		req.wr_en    = 1'b0;
		req.wr_addr  = lbl_q;
		req.wr_data  = (count == COUNT_TOP) ? count : count + COUNT_WIDTH'(1);
		req.clear    = 1'b0;
		busy         = 1'b1;
		result_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy        = 1'b0;
				req.rd_addr = IDX_W'(neighbor_label);
			end
			ST_VOTE:  req.wr_en = in_tbl_q;
			ST_SCAN:  req.rd_addr = cnt_q;
			ST_DRAIN: ;
			ST_EMIT: begin
				result_valid = 1'b1;
				req.clear    = 1'b1;
			end
			default: ;
		endcase
	end

	// bins of the replaced label and of unclassified vote as zero
	assign excluded = (tag_s1 == UNCLASSIFIED_LABEL) ||
		(32'(tag_s1) == 32'(replaced_label));
	assign cand     = excluded ? '0 : count;
	assign better   = tag_vld_s1 && (cand > best_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			tag_vld_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			tag_vld_s1 <= (state_q == ST_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		tag_s1 <= cnt_q;
		if (accept) begin
			lbl_q    <= IDX_W'(neighbor_label);
			in_tbl_q <= in_tbl;
			last_q   <= last_neighbor;
			keep_q   <= no_neighbors;
			best_q   <= '0;
		end
		if (state_q == ST_VOTE) begin
			cnt_q      <= '0;
			best_q     <= '0;
			best_cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + IDX_W'(1);
		end
		if (better) begin
			best_q     <= tag_s1;
			best_cnt_q <= cand;
		end
	end

	assign voted_label = LABEL_W'(best_q);
	assign keep_label  = keep_q;

endmodule

// ===== hw/rtl/neighbor_majority_label_vote_core.sv =====
// top level of the neighbor majority label vote core
// One neighbor label is taken per request while busy is low. A neighbor that is
// not the last of its cell has its count read from the histogram ram and the
// saturated increment written back. For the last neighbor of a cell, after the
// increment, the shared compare unit walks every bin through the single ram
// read port, one label per cycle, and the voted label appears with result_valid
// high for one cycle. A request for a cell with no neighbors gives keep_label
// high. The result cannot be stalled; it is shown once and the histogram is
// cleared in the same cycle through its per-bin valid bits, so no clearing pass
// is needed after reset or between cells. replaced_label is written through the
// cfg channel, which is always ready.
module neighbor_majority_label_vote_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  nmlv_pkg::label_t neighbor_label,
	input  logic             last_neighbor,
	input  logic             no_neighbors,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  nmlv_pkg::label_t cfg_data,
	output logic             result_valid,
	output nmlv_pkg::label_t voted_label,
	output logic             keep_label
);
	import nmlv_pkg::*;

	label_t    replaced_q;
	hist_req_t req;
	count_t    count;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replaced_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			replaced_q <= cfg_data;
		end
	end

	nmlv_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.neighbor_label(neighbor_label),
		.last_neighbor (last_neighbor),
		.no_neighbors  (no_neighbors),
		.replaced_label(replaced_q),
		.req           (req),
		.count         (count),
		.result_valid  (result_valid),
		.voted_label   (voted_label),
		.keep_label    (keep_label)
	);

	nmlv_hist u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.count (count)
	);

endmodule

// ===== sim/testbench.sv =====
// self-checking testbench for the neighbor majority label vote core
module testbench;
	import nmlv_pkg::*;

	typedef struct packed {
		label_t voted;
		logic   keep;
	} vote_t;

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	label_t neighbor_label;
	logic   last_neighbor;
	logic   no_neighbors;
	logic   cfg_valid;
	logic   cfg_ready;
	label_t cfg_data;
	logic   result_valid;
	label_t voted_label;
	logic   keep_label;

	vote_t  pending_votes[$];
	count_t tally[NUM_LABELS];
	label_t cfg_replaced;
	int     errors;
	int     items_sent;
	bit     gaps_on;

	neighbor_majority_label_vote_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.neighbor_label (neighbor_label),
		.last_neighbor  (last_neighbor),
		.no_neighbors   (no_neighbors),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.voted_label    (voted_label),
		.keep_label     (keep_label)
	);

	always #1 clk = ~clk;

	function automatic void tally_clear();
		foreach (tally[i]) tally[i] = '0;
	endfunction

	// histogram update for one request; returns 1 when a vote result is due
	function automatic bit tally_vote(label_t lbl, logic last, logic none, output vote_t v);
		int     best;
		count_t best_n;
		v = '0;
		if (none) begin
			tally_clear();
			v.keep = 1'b1;
			return 1'b1;
		end
		if (int'(lbl) < NUM_LABELS && tally[lbl] != COUNT_TOP)
			tally[lbl] = tally[lbl] + 1'b1;
		if (!last)
			return 1'b0;
		if (int'(cfg_replaced) < NUM_LABELS)
			tally[cfg_replaced] = '0;
		tally[UNCLASSIFIED_LABEL] = '0;
		best = 0;
		best_n = tally[0];
		for (int i = 1; i < NUM_LABELS; i++) begin
			if (tally[i] > best_n) begin
				best = i;
				best_n = tally[i];
			end
		end
		tally_clear();
		v.voted = label_t'(best);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $time, what);
		errors++;
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	task automatic idle_gap();
		int n;
		n = gaps_on ? gap_len() : 0;
		if (n > 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_neighbor(label_t lbl, logic last, logic none);
		vote_t v;
		@(negedge clk);
		start = 1'b1;
		neighbor_label = lbl;
		last_neighbor = last;
		no_neighbors = none;
		@(posedge clk);
		while (busy) @(posedge clk);
		items_sent++;
		if (tally_vote(lbl, last, none, v))
			pending_votes.push_back(v);
		idle_gap();
	endtask

	// hold requests until every vote has come back and the core has settled
	task automatic drain_votes();
		@(negedge clk);
		start = 1'b0;
		while (pending_votes.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_replaced(label_t value);
		drain_votes();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_replaced = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic label_t pick_label();
		case ($urandom_range(0, 3))
			0: return label_t'($urandom_range(0, 3));
			1: return cfg_replaced;
			default: return label_t'($urandom);
		endcase
	endfunction

	task automatic send_cell(int len);
		for (int k = 0; k < len; k++)
			send_neighbor(pick_label(), k == len - 1, 1'b0);
	endtask

	always @(posedge clk) begin
		vote_t want;
		if (arst_n && result_valid) begin
			if (pending_votes.size() == 0) begin
				report_mismatch($sformatf("unexpected result, voted_label %0d keep_label %0b",
					voted_label, keep_label));
			end else begin
				want = pending_votes.pop_front();
				if (voted_label !== want.voted)
					report_mismatch($sformatf("voted_label %0d, expected %0d",
						voted_label, want.voted));
				if (keep_label !== want.keep)
					report_mismatch($sformatf("keep_label %0b, expected %0b",
						keep_label, want.keep));
			end
		end
	end

	task automatic test_directed();
		// cell without neighbors, label and last ignored
		send_neighbor(8'hFF, 1'b1, 1'b1);
		send_neighbor(8'h00, 1'b0, 1'b1);
		// replaced label resets to 0 so its votes drop out
		send_neighbor(8'd0, 1'b0, 1'b0);
		send_neighbor(8'd0, 1'b0, 1'b0);
		send_neighbor(8'd3, 1'b1, 1'b0);
		// unclassified votes never win
		send_neighbor(8'd1, 1'b0, 1'b0);
		send_neighbor(8'd1, 1'b0, 1'b0);
		send_neighbor(8'd1, 1'b0, 1'b0);
		send_neighbor(8'd2, 1'b1, 1'b0);
		// all counts zero gives label 0
		send_neighbor(8'd1, 1'b1, 1'b0);
		// tie goes to the lower label
		send_neighbor(8'd9, 1'b0, 1'b0);
		send_neighbor(8'd4, 1'b0, 1'b0);
		send_neighbor(8'd9, 1'b0, 1'b0);
		send_neighbor(8'd4, 1'b1, 1'b0);
		// partial run thrown away by a no-neighbor request
		send_neighbor(8'd7, 1'b0, 1'b0);
		send_neighbor(8'd7, 1'b0, 1'b0);
		send_neighbor(8'd7, 1'b1, 1'b1);
		send_neighbor(8'd5, 1'b1, 1'b0);
		send_neighbor(8'hFF, 1'b0, 1'b0);
		send_neighbor(8'hFF, 1'b0, 1'b0);
		send_neighbor(8'hFE, 1'b1, 1'b0);
		send_neighbor(8'h80, 1'b1, 1'b0);
	endtask

	task automatic test_config_sweep();
		label_t values[5];
		values = '{8'hFF, 8'h01, 8'h80, label_t'($urandom), 8'h00};
		foreach (values[i]) begin
			write_replaced(values[i]);
			repeat (4) send_cell($urandom_range(1, 8));
		end
	endtask

	// label a pushed past the count ceiling, label b brought just below, to or just past it
	task automatic test_saturation();
		label_t a;
		label_t b;
		int     na;
		int     nb;
		bit     take_a;
		gaps_on = 1'($urandom_range(0, 1));
		do a = label_t'($urandom); while (a == UNCLASSIFIED_LABEL || a == cfg_replaced);
		do b = label_t'($urandom); while (b == UNCLASSIFIED_LABEL || b == cfg_replaced || b == a);
		na = int'(COUNT_TOP) + 1 + $urandom_range(0, 20);
		nb = int'(COUNT_TOP) - 1 + $urandom_range(0, 2);
		while (na + nb > 0) begin
			take_a = (nb == 0) || (na > 0 && $urandom_range(0, 1));
			if (take_a)
				na--;
			else
				nb--;
			send_neighbor(take_a ? a : b, na + nb == 0, 1'b0);
		end
		gaps_on = 1'b1;
	endtask

	task automatic test_random_cells();
		int r;
		int len;
		int next_cfg;
		next_cfg = items_sent + 150;
		while (items_sent < 1650) begin
			if (items_sent >= next_cfg) begin
				write_replaced($urandom_range(0, 3) == 0 ? 8'h01 : label_t'($urandom));
				next_cfg = items_sent + $urandom_range(100, 200);
			end
			gaps_on = $urandom_range(0, 5) != 0;
			r = $urandom_range(0, 99);
			if (r < 80) begin
				send_cell($urandom_range(1, 8));
			end else if (r < 93) begin
				send_cell($urandom_range(9, 40));
			end else if (r < 97) begin
				send_neighbor(label_t'($urandom), 1'($urandom_range(0, 1)), 1'b1);
			end else begin
				// broken run cut off by a no-neighbor request
				len = $urandom_range(1, 6);
				for (int k = 0; k < len; k++)
					send_neighbor(pick_label(), 1'b0, 1'b0);
				send_neighbor(label_t'($urandom), 1'($urandom_range(0, 1)), 1'b1);
			end
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		neighbor_label = '0;
		last_neighbor = 1'b0;
		no_neighbors = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		items_sent = 0;
		gaps_on = 1'b1;
		cfg_replaced = '0;
		tally_clear();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_config_sweep();
		test_saturation();
		test_random_cells();

		drain_votes();
		repeat (NUM_LABELS + 8) @(posedge clk);
		if (pending_votes.size() != 0)
			report_mismatch($sformatf("%0d votes never arrived", pending_votes.size()));
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5000000;
		$display("tb: failure");
		$finish;
	end

endmodule
